/* sv/tqoa_pkg.sv */
// Package for two_queues_one_array: store geometry, pointer widths,
// action and status codes. No dependencies.
package tqoa_pkg;

  // Number of slots shared by the two queues
  localparam int DEPTH = 16;
  // Slot address width
  localparam int AW = $clog2(DEPTH);
  // Width of the position field of a request
  localparam int POS_W = 4;
  // Signed pointer width: holds -1 .. DEPTH and any position value
  localparam int PW = (($clog2(DEPTH + 1) + 1) > (POS_W + 1)) ?
                      ($clog2(DEPTH + 1) + 1) : (POS_W + 1);
  // Word width
  localparam int DW = 32;

  // Empty marks for the two queues
  localparam logic signed [PW-1:0] Q1_EMPTY = '1;
  localparam logic signed [PW-1:0] Q2_EMPTY = PW'(DEPTH);
  localparam logic signed [PW-1:0] Q2_FIRST = PW'(DEPTH - 1);

  // Request actions
  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_DELETE  = 3'd1;
  localparam logic [2:0] ACT_PEEK    = 3'd2;
  localparam logic [2:0] ACT_MODIFY  = 3'd3;
  localparam logic [2:0] ACT_DISPLAY = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

endpackage

/* sv/tqoa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tqoa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/two_queues_one_array.sv */
// Two queues in one array: top level. Uses tqoa_pkg and tqoa_ram.
// Insert, modify and status-only results are registered from the request; delete
// and peek data pass the RAM read register, then the output register (one slot
// read); display: words take the same path, one word per cycle, out_last on the
// last. busy is high during a delete, peek or display read; start is ignored then.
// Reset (rst_n low, synchronous) empties both queues; slots are not cleared.
module two_queues_one_array (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic                          in_which_queue,
  input  logic signed [tqoa_pkg::DW-1:0] in_value,
  input  logic [tqoa_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [tqoa_pkg::DW-1:0] out_data,
  output logic                          out_last
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DISP} state_t;

  state_t                          state_r, state_nxt;
  logic signed [tqoa_pkg::PW-1:0]  f1_r, f1_nxt, r1_r, r1_nxt;
  logic signed [tqoa_pkg::PW-1:0]  f2_r, f2_nxt, r2_r, r2_nxt;
  logic signed [tqoa_pkg::PW-1:0]  idx_r, idx_nxt;
  logic                            sel_r, sel_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic [tqoa_pkg::DW-1:0]         out_data_r, out_data_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            ram_we;
  logic signed [tqoa_pkg::PW-1:0]  wptr, rptr;
  logic [tqoa_pkg::DW-1:0]         ram_wdata, ram_rdata;

  logic                            accept;
  logic                            q_empty;
  logic signed [tqoa_pkg::PW-1:0]  pos_s, front_sel;
  logic                            bad_pos, disp_last;

  // Slot store
  tqoa_ram #(
    .WIDTH (tqoa_pkg::DW),
    .DEPTH (tqoa_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr[tqoa_pkg::AW-1:0]),
    .wdata (ram_wdata),
    .raddr (rptr[tqoa_pkg::AW-1:0]),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Request decode helpers
  assign q_empty   = in_which_queue ? (f2_r == tqoa_pkg::Q2_EMPTY)
                                    : (f1_r == tqoa_pkg::Q1_EMPTY);
  assign pos_s     = $signed({{(tqoa_pkg::PW - tqoa_pkg::POS_W){1'b0}}, in_position});
  assign front_sel = in_which_queue ? f2_r : f1_r;
  assign bad_pos   = in_which_queue ? ((pos_s > f2_r) || (pos_s < r2_r))
                                    : ((pos_s < f1_r) || (pos_s > r1_r));
  assign disp_last = sel_r ? (idx_r == r2_r) : (idx_r == r1_r);

  // Next-state, RAM access and result word
  always_comb begin
    state_nxt      = state_r;
    f1_nxt         = f1_r;
    r1_nxt         = r1_r;
    f2_nxt         = f2_r;
    r2_nxt         = r2_r;
    idx_nxt        = idx_r;
    sel_nxt        = sel_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = tqoa_pkg::ST_OK;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;
    ram_we         = 1'b0;
    wptr           = pos_s;
    ram_wdata      = in_value;
    rptr           = front_sel;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            tqoa_pkg::ACT_INSERT: begin
              out_valid_nxt = 1'b1;
              if (r1_r == r2_r - 2'sd1) begin
                out_status_nxt = tqoa_pkg::ST_FULL;
              end else if (!in_which_queue) begin
                r1_nxt = r1_r + 2'sd1;
                wptr   = r1_r + 2'sd1;
                ram_we = 1'b1;
                if (f1_r == tqoa_pkg::Q1_EMPTY) f1_nxt = '0;
              end else begin
                r2_nxt = r2_r - 2'sd1;
                wptr   = r2_r - 2'sd1;
                ram_we = 1'b1;
                if (f2_r == tqoa_pkg::Q2_EMPTY) f2_nxt = tqoa_pkg::Q2_FIRST;
              end
            end
            tqoa_pkg::ACT_DELETE: begin
              if (q_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tqoa_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_READ;
                // front word is read now; pointers move at once
                if (!in_which_queue) begin
                  if (f1_r == r1_r) begin
                    f1_nxt = tqoa_pkg::Q1_EMPTY;
                    r1_nxt = tqoa_pkg::Q1_EMPTY;
                  end else begin
                    f1_nxt = f1_r + 2'sd1;
                  end
                end else begin
                  if (f2_r == r2_r) begin
                    f2_nxt = tqoa_pkg::Q2_EMPTY;
                    r2_nxt = tqoa_pkg::Q2_EMPTY;
                  end else begin
                    f2_nxt = f2_r - 2'sd1;
                  end
                end
              end
            end
            tqoa_pkg::ACT_PEEK: begin
              if (q_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tqoa_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_READ;
              end
            end
            tqoa_pkg::ACT_MODIFY: begin
              out_valid_nxt = 1'b1;
              if (q_empty) begin
                out_status_nxt = tqoa_pkg::ST_EMPTY;
              end else if (bad_pos) begin
                out_status_nxt = tqoa_pkg::ST_BADPOS;
              end else begin
                ram_we = 1'b1;
              end
            end
            tqoa_pkg::ACT_DISPLAY: begin
              if (q_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tqoa_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_DISP;
                idx_nxt   = front_sel;
                sel_nxt   = in_which_queue;
              end
            end
            default: begin
              // unused action codes give no result
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rdata;
        state_nxt     = S_IDLE;
      end
      S_DISP: begin
        // ram_rdata holds the word at idx_r
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rdata;
        out_last_nxt  = disp_last;
        if (disp_last) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = sel_r ? (idx_r - 2'sd1) : (idx_r + 2'sd1);
          rptr    = idx_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      f1_r        <= tqoa_pkg::Q1_EMPTY;
      r1_r        <= tqoa_pkg::Q1_EMPTY;
      f2_r        <= tqoa_pkg::Q2_EMPTY;
      r2_r        <= tqoa_pkg::Q2_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      f1_r        <= f1_nxt;
      r1_r        <= r1_nxt;
      f2_r        <= f2_nxt;
      r2_r        <= r2_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    sel_r        <= sel_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

endmodule

/* dv/two_queues_one_array_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for two_queues_one_array: random and directed requests
// on both queues, replies checked word by word against an in-bench queue model.
// Depends on tqoa_pkg and the two_queues_one_array RTL.
module two_queues_one_array_tb;
  import tqoa_pkg::*;

  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int RAND_BLOCKS  = 11;
  localparam int BLOCK_LEN    = 10;

  // Stimulus mix per block of random requests
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_ANY   = 2;

  typedef struct {
    logic [2:0]          action;
    logic                which_queue;
    logic signed [DW-1:0] value;
    logic [POS_W-1:0]    position;
    int                  gap;
  } request_t;

  typedef struct {
    logic [1:0]          status;
    logic signed [DW-1:0] data;
    logic                last;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [2:0]           in_action = ACT_INSERT;
  logic                 in_which_queue = 1'b0;
  logic signed [DW-1:0] in_value = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic                 out_valid;
  logic [1:0]           out_status;
  logic signed [DW-1:0] out_data;
  logic                 out_last;

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  bit       calm_gaps;
  logic     took;
  int       gap_left = -1;
  int       stall_cycles = 0;
  int       fail_count = 0;

  // Shadow copy of the shared store and the four queue pointers
  logic signed [DW-1:0] shadow_slots[DEPTH];
  int low_front, low_rear, up_front, up_rear;

  two_queues_one_array dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_which_queue (in_which_queue),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_data       (out_data),
    .out_last       (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void add_request(logic [2:0] act, logic q, logic signed [DW-1:0] v,
                                      int pos);
    request_t r;
    r.action      = act;
    r.which_queue = q;
    r.value       = v;
    r.position    = POS_W'(pos);
    r.gap         = (calm_gaps || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    pending_requests.push_back(r);
  endfunction

  function automatic void push_reply(logic [1:0] st, logic signed [DW-1:0] d, logic lst);
    reply_t w;
    w.status = st;
    w.data   = d;
    w.last   = lst;
    expected_replies.push_back(w);
  endfunction

  // Queue model: updates the shadow state and queues the reply words of one request
  function automatic void predict_replies(request_t r);
    bit upper;
    bit none_held;
    int p;
    int k;
    upper     = r.which_queue;
    none_held = upper ? (up_front == DEPTH) : (low_front == -1);
    p         = int'(r.position);
    case (r.action)
      ACT_INSERT: begin
        if (low_rear == up_rear - 1) begin
          push_reply(ST_FULL, '0, 1'b1);
        end else begin
          if (!upper) begin
            low_rear++;
            shadow_slots[low_rear] = r.value;
            if (low_front == -1) low_front = 0;
          end else begin
            up_rear--;
            shadow_slots[up_rear] = r.value;
            if (up_front == DEPTH) up_front = DEPTH - 1;
          end
          push_reply(ST_OK, '0, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (none_held) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else if (!upper) begin
          push_reply(ST_OK, shadow_slots[low_front], 1'b1);
          // last entry out: queue goes back to empty
          if (low_front == low_rear) begin
            low_front = -1;
            low_rear  = -1;
          end else begin
            low_front++;
          end
        end else begin
          push_reply(ST_OK, shadow_slots[up_front], 1'b1);
          if (up_front == up_rear) begin
            up_front = DEPTH;
            up_rear  = DEPTH;
          end else begin
            up_front--;
          end
        end
      end
      ACT_PEEK: begin
        if (none_held) push_reply(ST_EMPTY, '0, 1'b1);
        else push_reply(ST_OK, shadow_slots[upper ? up_front : low_front], 1'b1);
      end
      ACT_MODIFY: begin
        if (none_held) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else if (!upper ? (p < low_front || p > low_rear)
                            : (p > up_front || p < up_rear)) begin
          push_reply(ST_BADPOS, '0, 1'b1);
        end else begin
          shadow_slots[p] = r.value;
          push_reply(ST_OK, '0, 1'b1);
        end
      end
      ACT_DISPLAY: begin
        if (none_held) begin
          push_reply(ST_EMPTY, '0, 1'b1);
        end else if (!upper) begin
          for (k = low_front; k <= low_rear; k++)
            push_reply(ST_OK, shadow_slots[k], k == low_rear);
        end else begin
          for (k = up_front; k >= up_rear; k--)
            push_reply(ST_OK, shadow_slots[k], k == up_rear);
        end
      end
      default: ;  // unused codes are ignored
    endcase
  endfunction

  function automatic logic [2:0] pick_action(int mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 65) return ACT_INSERT;
        if (roll < 75) return ACT_DISPLAY;
        if (roll < 85) return ACT_MODIFY;
        if (roll < 95) return ACT_PEEK;
        return ACT_DELETE;
      end
      MIX_DRAIN: begin
        if (roll < 60) return ACT_DELETE;
        if (roll < 70) return ACT_DISPLAY;
        if (roll < 80) return ACT_PEEK;
        if (roll < 90) return ACT_MODIFY;
        return ACT_INSERT;
      end
      default: begin
        if (roll < 95) return 3'($urandom_range(0, 4));
        return 3'($urandom_range(5, 7));
      end
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_requests.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (gap_left < 0) gap_left = pending_requests[0].gap;
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else begin
          r = pending_requests.pop_front();
          in_action      <= r.action;
          in_which_queue <= r.which_queue;
          in_value       <= r.value;
          in_position    <= r.position;
          start          <= 1'b1;
          gap_left = -1;
        end
      end
    end
  end

  // Monitor: check reply words, then model any request taken at this edge
  always @(posedge clk) begin
    reply_t   want;
    request_t seen;
    if (!rst_n) begin
      took         <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected word status=%0d data=%0d last=%0b", $time,
                   out_status, out_data, out_last);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            fail_count++;
          end
          if (out_data !== want.data) begin
            $display("%0t: data expected %0d actual %0d", $time, want.data, out_data);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        seen.action      = in_action;
        seen.which_queue = in_which_queue;
        seen.value       = in_value;
        seen.position    = in_position;
        seen.gap         = 0;
        predict_replies(seen);
      end
      took         <= start && !busy;
      stall_cycles <= (out_valid || (start && !busy)) ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    @(posedge rst_n);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int mix;
    low_front = -1;
    low_rear  = -1;
    up_front  = DEPTH;
    up_rear   = DEPTH;
    calm_gaps = 1'b0;

    // Directed: empty queues, extremes, both queues, bad positions, last-entry delete
    add_request(ACT_DISPLAY, 1'b0, '0, 0);
    add_request(ACT_DELETE,  1'b1, '0, 0);
    add_request(ACT_PEEK,    1'b0, '0, 0);
    add_request(ACT_MODIFY,  1'b1, 32'sd5, 15);
    add_request(ACT_INSERT,  1'b0, 32'sh7FFF_FFFF, 0);
    add_request(ACT_INSERT,  1'b0, 32'sh8000_0000, 15);
    add_request(ACT_INSERT,  1'b1, '1, 0);
    add_request(ACT_INSERT,  1'b1, '0, 0);
    add_request(ACT_PEEK,    1'b1, '0, 0);
    add_request(ACT_MODIFY,  1'b0, 32'shA5A5_A5A5, 1);
    add_request(ACT_MODIFY,  1'b0, 32'sd1, 15);
    add_request(ACT_MODIFY,  1'b1, 32'sh5A5A_5A5A, 15);
    add_request(ACT_MODIFY,  1'b1, 32'sd2, 0);
    add_request(3'd5,        1'b0, '1, 15);
    add_request(ACT_DISPLAY, 1'b0, '0, 0);
    add_request(ACT_DISPLAY, 1'b1, '0, 0);
    add_request(ACT_DELETE,  1'b0, '0, 0);
    add_request(ACT_DELETE,  1'b0, '0, 0);
    add_request(ACT_DELETE,  1'b1, '0, 0);
    add_request(3'd7,        1'b1, '0, 0);
    add_request(ACT_PEEK,    1'b1, '0, 0);

    // Random blocks: fill-heavy, drain-heavy or mixed; the tail runs without gaps
    for (int b = 0; b < RAND_BLOCKS; b++) begin
      mix       = (b < 2) ? MIX_FILL : $urandom_range(MIX_FILL, MIX_ANY);
      calm_gaps = (b >= RAND_BLOCKS - 3) || ($urandom_range(0, 3) == 0);
      for (int j = 0; j < BLOCK_LEN; j++)
        add_request(pick_action(mix), 1'($urandom_range(0, 1)), pick_value(),
                    $urandom_range(0, 15));
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_requests.size() != 0 || start) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
